>>> hw/rtl/lpmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Length-prefixed message deframer package
// Shared types, event codes and the frame type lookup.
// ----------------------------------------------------------------------------
package lpmd_pkg;

  localparam int unsigned LenW     = 31;
  localparam int unsigned WordW    = 32;
  localparam int unsigned HdrCntW  = 3;
  localparam int unsigned EventW   = 4;

  localparam logic [LenW-1:0]  MAX_LENGTH_RESET = 31'd10236;
  localparam logic [LenW-1:0]  LEN_SAT          = 31'h7FFF_FFFF;
  localparam logic [WordW-1:0] HDR_WORD_BYTES   = 32'd4;

  // Frame type words on the link.
  localparam logic [WordW-1:0] TYPE_HEARTBEAT   = 32'd99;
  localparam logic [WordW-1:0] TYPE_START_CONST = 32'd4;
  localparam logic [WordW-1:0] TYPE_STOP_CONST  = 32'd5;
  localparam logic [WordW-1:0] TYPE_START_CSI   = 32'd7;
  localparam logic [WordW-1:0] TYPE_STOP_CSI    = 32'd8;
  localparam logic [WordW-1:0] TYPE_INQUIRY     = 32'd1;
  localparam logic [WordW-1:0] TYPE_RSSI        = 32'd2;
  localparam logic [WordW-1:0] TYPE_RF_STATE    = 32'd22;

  // Event codes reported on the result channel.
  localparam logic [EventW-1:0] EV_HEARTBEAT   = 4'd0;
  localparam logic [EventW-1:0] EV_START_CONST = 4'd1;
  localparam logic [EventW-1:0] EV_STOP_CONST  = 4'd2;
  localparam logic [EventW-1:0] EV_START_CSI   = 4'd3;
  localparam logic [EventW-1:0] EV_STOP_CSI    = 4'd4;
  localparam logic [EventW-1:0] EV_INQUIRY     = 4'd5;
  localparam logic [EventW-1:0] EV_RSSI        = 4'd6;
  localparam logic [EventW-1:0] EV_RF_STATE    = 4'd7;
  localparam logic [EventW-1:0] EV_MALFORMED   = 4'd8;

  typedef enum logic [1:0] {
    PH_LEN  = 2'd0,
    PH_TYPE = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic [EventW-1:0] event_res;
    logic              data_valid;
    logic [7:0]        data_byte;
    logic [LenW-1:0]   payload_length;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } result_t;

  typedef struct packed {
    logic              known;
    logic [EventW-1:0] code;
  } type_map_t;

  function automatic type_map_t map_type(input logic [WordW-1:0] tw);
    type_map_t m;
    m.known = 1'b1;
    m.code  = EV_HEARTBEAT;
    case (tw)
      TYPE_HEARTBEAT:   m.code = EV_HEARTBEAT;
      TYPE_START_CONST: m.code = EV_START_CONST;
      TYPE_STOP_CONST:  m.code = EV_STOP_CONST;
      TYPE_START_CSI:   m.code = EV_START_CSI;
      TYPE_STOP_CSI:    m.code = EV_STOP_CSI;
      TYPE_INQUIRY:     m.code = EV_INQUIRY;
      TYPE_RSSI:        m.code = EV_RSSI;
      TYPE_RF_STATE:    m.code = EV_RF_STATE;
      default:          m.known = 1'b0;
    endcase
    return m;
  endfunction

endpackage

>>> hw/rtl/lpmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer stream interfaces
// Valid/ready channels for received bytes and for deframed results.
// ----------------------------------------------------------------------------
interface lpmd_in_if import lpmd_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lpmd_out_if import lpmd_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/lpmd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer frame parser
// Tracks header and payload position of the byte stream and forms at most
// one result for every accepted byte.
// ----------------------------------------------------------------------------
module lpmd_parser import lpmd_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  in_item_t        item,
  input  logic [LenW-1:0] max_length,
  output result_t         res
);

  phase_t               phase_r, phase_nxt;
  logic [HdrCntW-1:0]   header_count_r, header_count_nxt;
  logic [WordW-1:0]     frame_length_r, frame_length_nxt;
  logic [WordW-1:0]     type_word_r, type_word_nxt;
  logic [LenW-1:0]      bytes_left_r, bytes_left_nxt;
  logic                 forwarding_r, forwarding_nxt;
  logic [EventW-1:0]    current_event_r, current_event_nxt;

  logic [HdrCntW-1:0]   hdr_inc;
  logic                 hdr_done;
  logic [WordW-1:0]     length_shift;
  logic [WordW-1:0]     type_shift;
  logic                 malformed;
  logic [LenW-1:0]      skip_len;
  logic [LenW-1:0]      payload_len;
  logic [LenW-1:0]      bl_dec;
  type_map_t            tmap;
  logic                 tmap_fwd;

  assign hdr_inc      = header_count_r + 1'b1;
  // The header word is complete once four bytes have been counted.
  assign hdr_done     = hdr_inc[2];
  assign length_shift = {frame_length_r[23:0], item.rx_byte};
  assign type_shift   = {type_word_r[23:0], item.rx_byte};
  assign malformed    = (length_shift < HDR_WORD_BYTES) ||
                        (length_shift > {1'b0, max_length});
  assign skip_len     = length_shift[WordW-1] ? LEN_SAT : length_shift[LenW-1:0];
  assign payload_len  = frame_length_r[LenW-1:0] - HDR_WORD_BYTES[LenW-1:0];
  assign bl_dec       = bytes_left_r - 1'b1;
  assign tmap         = map_type(type_shift);
  assign tmap_fwd     = tmap.known && (tmap.code == EV_INQUIRY || tmap.code == EV_RSSI);

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      if (item.restart) begin
        phase_nxt = PH_LEN;
      end else begin
        case (phase_r)
          PH_TYPE: begin
            if (hdr_done) begin
              phase_nxt = (payload_len == '0) ? PH_LEN : PH_BODY;
            end
          end
          PH_BODY: begin
            if (bl_dec == '0) begin
              phase_nxt = PH_LEN;
            end
          end
          default: begin
            phase_nxt = PH_LEN;
            if (hdr_done) begin
              if (malformed) begin
                phase_nxt = (skip_len == '0) ? PH_LEN : PH_BODY;
              end else begin
                phase_nxt = PH_TYPE;
              end
            end
          end
        endcase
      end
    end
  end

  // Counters, frame context and the result.
  always_comb begin
    header_count_nxt  = header_count_r;
    frame_length_nxt  = frame_length_r;
    type_word_nxt     = type_word_r;
    bytes_left_nxt    = bytes_left_r;
    forwarding_nxt    = forwarding_r;
    current_event_nxt = current_event_r;
    res               = '0;
    if (accept) begin
      if (item.restart) begin
        header_count_nxt  = '0;
        frame_length_nxt  = '0;
        type_word_nxt     = '0;
        bytes_left_nxt    = '0;
        forwarding_nxt    = 1'b0;
        current_event_nxt = EV_HEARTBEAT;
      end else begin
        case (phase_r)
          PH_TYPE: begin
            type_word_nxt    = type_shift;
            header_count_nxt = hdr_inc;
            if (hdr_done) begin
              header_count_nxt  = '0;
              bytes_left_nxt    = payload_len;
              forwarding_nxt    = tmap_fwd;
              current_event_nxt = tmap.known ? tmap.code : EV_HEARTBEAT;
              res.valid               = tmap.known;
              res.item.event_res      = tmap.code;
              res.item.payload_length = payload_len;
              res.item.last           = (payload_len == '0) || !tmap_fwd;
            end
          end
          PH_BODY: begin
            bytes_left_nxt = bl_dec;
            if (forwarding_r) begin
              res.valid               = 1'b1;
              res.item.event_res      = current_event_r;
              res.item.data_valid     = 1'b1;
              res.item.data_byte      = item.rx_byte;
              res.item.payload_length = payload_len;
              res.item.last           = (bl_dec == '0);
            end
          end
          default: begin
            frame_length_nxt = length_shift;
            header_count_nxt = hdr_inc;
            if (hdr_done) begin
              header_count_nxt = '0;
              type_word_nxt    = '0;
              if (malformed) begin
                bytes_left_nxt     = skip_len;
                forwarding_nxt     = 1'b0;
                current_event_nxt  = EV_MALFORMED;
                res.valid          = 1'b1;
                res.item.event_res = EV_MALFORMED;
                res.item.last      = 1'b1;
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_LEN;
      header_count_r  <= '0;
      frame_length_r  <= '0;
      type_word_r     <= '0;
      bytes_left_r    <= '0;
      forwarding_r    <= 1'b0;
      current_event_r <= EV_HEARTBEAT;
    end else begin
      phase_r         <= phase_nxt;
      header_count_r  <= header_count_nxt;
      frame_length_r  <= frame_length_nxt;
      type_word_r     <= type_word_nxt;
      bytes_left_r    <= bytes_left_nxt;
      forwarding_r    <= forwarding_nxt;
      current_event_r <= current_event_nxt;
    end
  end

`ifndef SYNTHESIS
  // A payload phase always has at least one byte still to come.
  a_body_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BODY |-> bytes_left_r != '0)
    else $error("payload phase with no bytes left");

  // The header byte counter never passes the last byte of a word.
  a_hdr_count: assert property (@(posedge clk) disable iff (!rst_n)
    !header_count_r[2])
    else $error("header byte count out of range");

  // Forwarded payload bytes only belong to json frames.
  a_fwd_event: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && res.item.data_valid |->
      (res.item.event_res == EV_INQUIRY || res.item.event_res == EV_RSSI))
    else $error("payload byte forwarded for a non-json frame");

  // Forwarding is only armed by a completed json type word.
  a_fwd_arm: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(forwarding_r) |-> $past(phase_r) == PH_TYPE)
    else $error("forwarding armed outside the type header");
`endif

endmodule

>>> hw/rtl/lpmd_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer result register
// Holds one result until the sink takes it and paces input acceptance.
// ----------------------------------------------------------------------------
module lpmd_out_reg import lpmd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  result_t   res,
  output logic      take_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;

  // A new byte may enter while the register is empty or when the held result leaves in the same cycle.
  assign take_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (accept) begin
      out_valid_nxt = res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res.valid) begin
      out_item_r <= res.item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  // A byte is only taken when the result register has room for its result.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> !out_valid_r || out_ready)
    else $error("result register overwritten while held");

  // A held result that was not taken stays unchanged.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_item_r))
    else $error("stalled result changed");

  // A result appears only after a byte was taken.
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(accept))
    else $error("result without an accepted byte");
`endif

endmodule

>>> hw/rtl/length_prefixed_message_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Length-prefixed message deframer
// Splits a byte stream of length/type framed messages into events and
// forwarded json payload bytes.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload                                      Handshake
// in_chan   sink       rx_byte, restart                             valid/ready
// out_chan  source     event_res, data_valid, data_byte,            valid/ready
//                      payload_length, last
// cfg_*     write      max_length (31 bits)                         write enable
//
// A byte can enter in every cycle while in_chan.ready is high.
// Its result, if any, appears in the result register in the cycle after the
// transaction and in_chan.ready follows that register: it is high while the
// register is empty or being drained in the same cycle.
// Reset is synchronous and active low; max_length returns to 10236.
// ----------------------------------------------------------------------------
module length_prefixed_message_deframer import lpmd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  lpmd_in_if.sink            in_chan,
  lpmd_out_if.source         out_chan,
  input  logic               cfg_we,
  input  logic [LenW-1:0]    cfg_wdata
);

  logic            accept;
  logic            take_ready;
  logic [LenW-1:0] max_length_r;
  result_t         res;

  assign in_chan.ready = take_ready;
  assign accept        = in_chan.valid && take_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= MAX_LENGTH_RESET;
    end else if (cfg_we) begin
      max_length_r <= cfg_wdata;
    end
  end

  lpmd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .item       (in_chan.data),
    .max_length (max_length_r),
    .res        (res)
  );

  lpmd_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .res        (res),
    .take_ready (take_ready),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .out_item   (out_chan.data)
  );

endmodule

>>> test/length_prefixed_message_deframer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Length-prefixed message deframer testbench
// Sends framed byte streams (all known and unknown types, malformed lengths,
// cut-off frames, restarts, noise) under random gaps and output stalls, and
// checks every event and forwarded payload byte against a cycle-free
// predictor of the deframer. The length limit is moved through several
// settings between phases, the extremes among them.
// ----------------------------------------------------------------------------
module length_prefixed_message_deframer_test;
  import lpmd_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int SettleCycles  = 4;
  localparam int MaxPrinted    = 200;
  localparam int RandomBytes   = 1000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [LenW-1:0] cfg_wdata;

  lpmd_in_if  in_chan ();
  lpmd_out_if out_chan ();

  length_prefixed_message_deframer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state.
  phase_t          rx_phase;
  logic [2:0]      hdr_cnt;
  logic [31:0]     len_word;
  logic [31:0]     type_word;
  logic [LenW-1:0] remaining;
  logic            forwarding;
  logic [3:0]      frame_event;
  logic [LenW-1:0] max_len;

  out_item_t deframed_q[$];
  int        mismatches = 0;
  int        bytes_sent = 0;
  int        idle_count = 0;
  logic      steady = 1'b0;
  int        steady_left = 0;
  int        stall_left = 0;

  logic [31:0] known_types [8] = '{TYPE_HEARTBEAT, TYPE_START_CONST, TYPE_STOP_CONST,
                                   TYPE_START_CSI, TYPE_STOP_CSI, TYPE_INQUIRY,
                                   TYPE_RSSI, TYPE_RF_STATE};

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic decode_type(input logic [31:0] tw, output logic [3:0] code);
    code = EV_HEARTBEAT;
    decode_type = 1'b1;
    case (tw)
      TYPE_HEARTBEAT:   code = EV_HEARTBEAT;
      TYPE_START_CONST: code = EV_START_CONST;
      TYPE_STOP_CONST:  code = EV_STOP_CONST;
      TYPE_START_CSI:   code = EV_START_CSI;
      TYPE_STOP_CSI:    code = EV_STOP_CSI;
      TYPE_INQUIRY:     code = EV_INQUIRY;
      TYPE_RSSI:        code = EV_RSSI;
      TYPE_RF_STATE:    code = EV_RF_STATE;
      default:          decode_type = 1'b0;
    endcase
  endfunction

  task automatic clear_frame_state();
    rx_phase    = PH_LEN;
    hdr_cnt     = '0;
    len_word    = '0;
    type_word   = '0;
    remaining   = '0;
    forwarding  = 1'b0;
    frame_event = EV_HEARTBEAT;
  endtask

  task automatic push_result(input logic [3:0] ev, input logic dv, input logic [7:0] db,
                             input logic [LenW-1:0] plen, input logic lst);
    out_item_t r;
    r.event_res      = ev;
    r.data_valid     = dv;
    r.data_byte      = db;
    r.payload_length = plen;
    r.last           = lst;
    deframed_q.push_back(r);
  endtask

  task automatic deframe_byte(input logic [7:0] b, input logic restart);
    logic       known;
    logic [3:0] code;
    if (restart) begin
      clear_frame_state();
      return;
    end
    case (rx_phase)
      PH_TYPE: begin
        type_word = {type_word[23:0], b};
        hdr_cnt   = hdr_cnt + 3'd1;
        if (hdr_cnt < 3'd4) return;
        hdr_cnt     = '0;
        remaining   = len_word[LenW-1:0] - 31'd4;
        known       = decode_type(type_word, code);
        forwarding  = known && (code == EV_INQUIRY || code == EV_RSSI);
        frame_event = known ? code : EV_HEARTBEAT;
        rx_phase    = (remaining == '0) ? PH_LEN : PH_BODY;
        if (known)
          push_result(frame_event, 1'b0, 8'd0, remaining, remaining == '0 || !forwarding);
      end
      PH_BODY: begin
        remaining = remaining - 31'd1;
        if (remaining == '0) rx_phase = PH_LEN;
        if (forwarding)
          push_result(frame_event, 1'b1, b, len_word[LenW-1:0] - 31'd4, remaining == '0);
      end
      default: begin
        // Any other phase code is treated as the length header.
        rx_phase = PH_LEN;
        len_word = {len_word[23:0], b};
        hdr_cnt  = hdr_cnt + 3'd1;
        if (hdr_cnt < 3'd4) return;
        hdr_cnt   = '0;
        type_word = '0;
        if (len_word < 32'd4 || len_word > {1'b0, max_len}) begin
          // Skip that many bytes; a length beyond 31 bits saturates.
          remaining   = len_word[31] ? LEN_SAT : len_word[LenW-1:0];
          forwarding  = 1'b0;
          frame_event = EV_MALFORMED;
          rx_phase    = (remaining == '0) ? PH_LEN : PH_BODY;
          push_result(EV_MALFORMED, 1'b0, 8'd0, '0, 1'b1);
        end else begin
          rx_phase = PH_TYPE;
        end
      end
    endcase
  endtask

  // ------------------------------------------------------------------ checker

  function automatic void check_field(input string fname, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MaxPrinted)
        $display("%0t: %s expected %0h, actual %0h", $time, fname, want, got);
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (deframed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxPrinted)
          $display("%0t: unexpected result, expected none, actual %p", $time, out_chan.data);
      end else begin
        want = deframed_q.pop_front();
        check_field("event_res", 32'(want.event_res), 32'(out_chan.data.event_res));
        check_field("data_valid", 32'(want.data_valid), 32'(out_chan.data.data_valid));
        check_field("data_byte", 32'(want.data_byte), 32'(out_chan.data.data_byte));
        check_field("payload_length", 32'(want.payload_length),
                    32'(out_chan.data.payload_length));
        check_field("last", 32'(want.last), 32'(out_chan.data.last));
      end
    end
  end

  // Ends the run when no transaction happens on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
      if (idle_count + 1 >= WatchdogLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------ gaps, stalls

  function automatic int idle_cycles();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Picks each stretch at random to be one with random idling or one without.
  always @(posedge clk) begin
    if (steady_left == 0) begin
      steady      <= ($urandom_range(0, 3) == 0);
      steady_left <= $urandom_range(100, 400);
    end else begin
      steady_left <= steady_left - 1;
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left     <= stall_left - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= 1'b1;
      stall_left     <= idle_cycles();
    end
  end

  // ------------------------------------------------------------------ driving

  task automatic send_byte(input logic [7:0] b, input logic restart);
    int g;
    g = idle_cycles();
    if (g > 0) begin
      in_chan.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data  <= '{rx_byte: b, restart: restart};
    do @(posedge clk); while (!in_chan.ready);
    deframe_byte(b, restart);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_restart();
    send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Sends a length word, an optional type word and body bytes. A cut position
  // inside the frame replaces the rest of it with a restart.
  task automatic send_frame(input logic [31:0] len, input logic with_type,
                            input logic [31:0] typ, input int body, input int cut);
    logic [7:0] fb[$];
    int k;
    for (k = 3; k >= 0; k--) fb.push_back(len[8*k +: 8]);
    if (with_type)
      for (k = 3; k >= 0; k--) fb.push_back(typ[8*k +: 8]);
    repeat (body) fb.push_back(8'($urandom_range(0, 255)));
    for (k = 0; k < fb.size(); k++) begin
      if (k == cut) begin
        send_restart();
        return;
      end
      send_byte(fb[k], 1'b0);
    end
    if (cut == fb.size()) send_restart();
  endtask

  // Stops sending until every expected transaction has arrived.
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    while (deframed_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_max_length(input logic [LenW-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    max_len = value;
  endtask

  // -------------------------------------------------------------------- tests

  task automatic test_frame_types();
    int k;
    for (k = 0; k < 8; k++)
      send_frame(32'(4 + k % 3), 1'b1, known_types[k], k % 3, -1);
  endtask

  task automatic test_unknown_types();
    send_frame(32'd6, 1'b1, 32'hFFFF_FF00, 2, -1);
    send_frame(32'd4, 1'b1, 32'd0, 0, -1);
  endtask

  task automatic test_malformed_lengths();
    send_frame(32'd0, 1'b0, '0, 0, -1);
    send_frame(32'd3, 1'b0, '0, 3, -1);
    send_frame(32'hFFFF_FFFF, 1'b0, '0, 2, 6);
  endtask

  task automatic test_restart();
    send_frame(32'd6, 1'b1, TYPE_RSSI, 2, 2);
    send_frame(32'd6, 1'b1, TYPE_RSSI, 2, 6);
    send_frame(32'd9, 1'b1, TYPE_INQUIRY, 5, 10);
  endtask

  task automatic test_length_limits();
    // Reset value first: one past it is malformed.
    send_frame(32'd10237, 1'b0, '0, 1, 5);
    write_max_length(31'd4);
    send_frame(32'd4, 1'b1, TYPE_HEARTBEAT, 0, -1);
    send_frame(32'd5, 1'b0, '0, 5, -1);
    write_max_length('0);
    send_frame(32'd4, 1'b0, '0, 4, -1);
    write_max_length(LEN_SAT);
    send_frame(32'h7FFF_FFFF, 1'b1, TYPE_INQUIRY, 4, 12);
    send_frame(32'h8000_0000, 1'b0, '0, 2, 6);
    write_max_length(MAX_LENGTH_RESET);
    send_frame(32'd10236, 1'b1, TYPE_STOP_CONST, 1, 9);
  endtask

  function automatic logic [LenW-1:0] random_max_length();
    case ($urandom_range(0, 5))
      0:       return LEN_SAT;
      1:       return MAX_LENGTH_RESET;
      2:       return 31'd4;
      3:       return 31'($urandom_range(0, 3));
      4:       return 31'($urandom_range(5, 300));
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic int random_payload();
    int r;
    int pl;
    r = $urandom_range(0, 99);
    if (r < 90)      pl = $urandom_range(0, 12);
    else if (r < 97) pl = $urandom_range(13, 64);
    else             pl = $urandom_range(65, 300);
    if (32'(pl) > 32'(max_len) - 32'd4) pl = int'(max_len) - 4;
    return pl;
  endfunction

  task automatic send_malformed();
    logic [31:0] len;
    int r;
    int body;
    r = $urandom_range(0, 99);
    if (max_len < 31'd4) begin
      len = $urandom_range(0, 12);
      send_frame(len, 1'b0, '0, int'(len), -1);
    end else if (r < 40) begin
      len = $urandom_range(0, 3);
      send_frame(len, 1'b0, '0, int'(len), -1);
    end else if (r < 70 && max_len < 31'd300) begin
      len = {1'b0, max_len} + 32'($urandom_range(1, 8));
      send_frame(len, 1'b0, '0, int'(len), -1);
    end else begin
      // Lengths too long to skip through are cut off by a restart.
      len = (r < 70) ? $urandom : ($urandom | 32'h8000_0000);
      if (len <= {1'b0, max_len}) len = {1'b0, max_len} + 32'd1;
      body = $urandom_range(0, 6);
      send_frame(len, 1'b0, '0, body, 4 + body);
    end
  endtask

  task automatic send_random_frame();
    int kind;
    int pl;
    int n;
    logic [31:0] typ;
    logic [3:0]  code;
    kind = $urandom_range(0, 99);
    if (max_len < 31'd4 && kind < 90) kind = 70;
    if (kind < 55) begin
      pl = random_payload();
      send_frame(32'(pl + 4), 1'b1, known_types[$urandom_range(0, 7)], pl, -1);
    end else if (kind < 65) begin
      do typ = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 40);
      while (decode_type(typ, code));
      pl = random_payload() % 9;
      send_frame(32'(pl + 4), 1'b1, typ, pl, -1);
    end else if (kind < 77) begin
      send_malformed();
    end else if (kind < 90) begin
      pl = random_payload();
      send_frame(32'(pl + 4), 1'b1, known_types[$urandom_range(0, 7)], pl,
                 $urandom_range(0, 8 + pl));
    end else begin
      n = $urandom_range(1, 12);
      repeat (n) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
      send_restart();
    end
  endtask

  task automatic test_random_traffic();
    int start;
    int mark;
    start = bytes_sent;
    mark  = bytes_sent;
    while (bytes_sent - start < RandomBytes) begin
      send_random_frame();
      if (bytes_sent - mark >= 250) begin
        mark = bytes_sent;
        write_max_length(random_max_length());
      end else if ($urandom_range(0, 49) == 0) begin
        drain_results();
      end
    end
  endtask

  // --------------------------------------------------------------------- main

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_chan.valid  = 1'b0;
    in_chan.data   = '0;
    max_len        = MAX_LENGTH_RESET;
    clear_frame_state();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_frame_types();
    test_unknown_types();
    test_malformed_lengths();
    test_restart();
    test_length_limits();
    test_random_traffic();

    drain_results();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> length_prefixed_message_deframer.f
hw/rtl/lpmd_pkg.sv
hw/rtl/lpmd_if.sv
hw/rtl/lpmd_parser.sv
hw/rtl/lpmd_out_reg.sv
hw/rtl/length_prefixed_message_deframer.sv
test/length_prefixed_message_deframer_test.sv
